// ----- rtl/gbs_pkg.sv -----
// Shared constants and types for the greedy box suppression block.
package gbs_pkg;

	localparam int MAX_KEPT   = 64;
	localparam int COORD_BITS = 16;
	localparam int AREA_W     = 2 * COORD_BITS;
	localparam int UNION_W    = AREA_W + 1;
	localparam int THR_W      = 16;
	localparam int PROD_W     = UNION_W + THR_W;
	localparam int IDX_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W      = 7;
	localparam int NUM_W      = 16;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(29491);

	// Register byte addresses on the configuration port.
	localparam int                APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] ADDR_THR = APB_ADDR_W'(0);

	// Controller state codes.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	typedef struct packed {
		logic [COORD_BITS-1:0] by;
		logic [COORD_BITS-1:0] rx;
		logic [COORD_BITS-1:0] ty;
		logic [COORD_BITS-1:0] lx;
	} box_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		box_t              box;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic pipe_busy;
		logic out_free;
	} status_t;

	function automatic logic [COORD_BITS-1:0] extent(input logic [COORD_BITS-1:0] lo,
		input logic [COORD_BITS-1:0] hi);
		return (hi > lo) ? (hi - lo) : '0;
	endfunction

endpackage

// ----- rtl/greedy_box_suppression_top.sv -----
// Greedy non-maximum suppression block: top level joining registers, controller and datapath.
// Each request is one score-ordered box; it is compared by intersection over union against
// every box kept so far in the current set and is either kept, suppressed, or flagged as an
// overflow when the 64-entry store is full. One box is processed at a time. Each box passes
// through an idle state, a preparation state, scan states that stream the kept boxes out
// of a single-read-port memory into a five-stage compare pipeline, drain states while the
// pipeline empties, and a commit state; scan and drain are skipped when the store is empty.
// The commit waits while the output register still holds a result that has not been taken.
// The next request is accepted while the previous result still waits in the output register.
// The threshold register must only be written while the block is idle.
module greedy_box_suppression_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [63:0]                    s_tdata,  // left_x, top_y, right_x, bottom_y
	input  logic                           s_tuser,  // first_box
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,  // kept, store_overflow, box_number,
	                                                 // kept_total, zero pad
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gbs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import gbs_pkg::*;

	cmd_t             cmd;
	status_t          status;
	logic [THR_W-1:0] threshold;
	box_t             in_box;
	logic             out_kept, out_overflow;
	logic [NUM_W-1:0] out_number;
	logic [CNT_W-1:0] out_total;

	assign in_box.lx = s_tdata[15:0];
	assign in_box.ty = s_tdata[31:16];
	assign in_box.rx = s_tdata[47:32];
	assign in_box.by = s_tdata[63:48];

	gbs_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	gbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gbs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.threshold    (threshold),
		.in_box       (in_box),
		.in_first     (s_tuser),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kept     (out_kept),
		.out_overflow (out_overflow),
		.out_number   (out_number),
		.out_total    (out_total)
	);

	assign m_tdata = {7'd0, out_total, out_number, out_overflow, out_kept};

endmodule

// ----- rtl/gbs_regs.sv -----
// Configuration register file with an APB-style port.
module gbs_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gbs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output logic [gbs_pkg::THR_W-1:0]      threshold
);
	import gbs_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_THR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (wr_en) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_THR) begin
			prdata[THR_W-1:0] = thr_q;
		end
	end

	assign threshold = thr_q;

endmodule

// ----- rtl/gbs_ctrl.sv -----
// Controller state machine that sequences one box through the scan.
module gbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gbs_pkg::status_t status,
	output gbs_pkg::cmd_t    cmd
);
	import gbs_pkg::*;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.scan_start = 1'b1;
				state_d = status.count_zero ? ST_COMMIT : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !status.count_zero)
		else $error("scan step issued on an empty store");

	a_commit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !status.pipe_busy)
		else $error("commit while compare pipeline still busy");

	a_load_then_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_PREP))
		else $error("accepted request did not move to preparation");

endmodule

// ----- rtl/gbs_dp.sv -----
// Datapath: kept-box memory, overlap compare pipeline, counters and result register.
module gbs_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gbs_pkg::cmd_t                cmd,
	output gbs_pkg::status_t             status,
	input  logic [gbs_pkg::THR_W-1:0]    threshold,
	input  gbs_pkg::box_t                in_box,
	input  logic                         in_first,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_kept,
	output logic                         out_overflow,
	output logic [gbs_pkg::NUM_W-1:0]    out_number,
	output logic [gbs_pkg::CNT_W-1:0]    out_total
);
	import gbs_pkg::*;

	entry_t mem [MAX_KEPT];

	box_t              box_q;
	logic [AREA_W-1:0] area_q;
	logic [NUM_W-1:0]  number_q;
	logic [NUM_W-1:0]  box_cnt_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic              suppress_q;
	logic              full;
	logic              keep;

	entry_t            rd_s1;
	logic              v_s1;
	logic [COORD_BITS-1:0] iw_s2, ih_s2;
	logic [AREA_W-1:0] ak_s2;
	logic              v_s2;
	logic [AREA_W-1:0] inter_s3, ak_s3;
	logic              v_s3;
	logic [UNION_W-1:0] uni_s4;
	logic [AREA_W-1:0] inter_s4;
	logic              v_s4;
	logic [PROD_W-1:0] prod_s5;
	logic [AREA_W-1:0] inter_s5;
	logic              v_s5;

	logic              out_valid_q;
	logic              kept_q, ovf_q;
	logic [NUM_W-1:0]  onum_q;
	logic [CNT_W-1:0]  otot_q;

	logic [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi;

	assign full = (count_q == CNT_W'(MAX_KEPT));
	assign keep = !suppress_q && !full;

	assign status.count_zero = (count_q == '0);
	assign status.scan_last  = ({{(CNT_W-IDX_W){1'b0}}, idx_q} == count_q - CNT_W'(1));
	assign status.pipe_busy  = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign status.out_free   = !out_valid_q || out_ready;

	// Box, numbering and store bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_cnt_q  <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			suppress_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				box_cnt_q <= (in_first ? '0 : box_cnt_q) + NUM_W'(1);
				if (in_first) begin
					count_q <= '0;
				end
			end
			if (cmd.scan_start) begin
				idx_q      <= '0;
				suppress_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (v_s5 && ({1'b0, inter_s5} > prod_s5[PROD_W-1:16])) begin
				suppress_q <= 1'b1;
			end
			if (cmd.commit && keep) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			box_q    <= in_box;
			number_q <= in_first ? '0 : box_cnt_q;
		end
		if (cmd.scan_start) begin
			area_q <= AREA_W'(extent(box_q.lx, box_q.rx)) * AREA_W'(extent(box_q.ty, box_q.by));
		end
	end

	// Kept-box memory: one write port at commit, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (cmd.commit && keep) begin
			mem[count_q[IDX_W-1:0]] <= '{area: area_q, box: box_q};
		end
		if (cmd.scan_step) begin
			rd_s1 <= mem[idx_q];
		end
	end

	assign x_lo = (box_q.lx > rd_s1.box.lx) ? box_q.lx : rd_s1.box.lx;
	assign x_hi = (box_q.rx < rd_s1.box.rx) ? box_q.rx : rd_s1.box.rx;
	assign y_lo = (box_q.ty > rd_s1.box.ty) ? box_q.ty : rd_s1.box.ty;
	assign y_hi = (box_q.by < rd_s1.box.by) ? box_q.by : rd_s1.box.by;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		iw_s2    <= extent(x_lo, x_hi);
		ih_s2    <= extent(y_lo, y_hi);
		ak_s2    <= rd_s1.area;
		inter_s3 <= AREA_W'(iw_s2) * AREA_W'(ih_s2);
		ak_s3    <= ak_s2;
		// Intersection never exceeds either area, so the union cannot go negative.
		uni_s4   <= UNION_W'(area_q) + UNION_W'(ak_s3) - UNION_W'(inter_s3);
		inter_s4 <= inter_s3;
		// floor(thr * union / 65536) is the exact quotient bound that the intersection is compared against.
		prod_s5  <= PROD_W'(threshold) * PROD_W'(uni_s4);
		inter_s5 <= inter_s4;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			kept_q <= keep;
			ovf_q  <= !suppress_q && full;
			onum_q <= number_q;
			otot_q <= keep ? count_q + CNT_W'(1) : count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kept     = kept_q;
	assign out_overflow = ovf_q;
	assign out_number   = onum_q;
	assign out_total    = otot_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEPT))
		else $error("kept count beyond store depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && keep) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("kept count did not advance on a stored box");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(kept_q && ovf_q))
		else $error("result both kept and overflowed");

endmodule
